// File: hdl/vector_distance_l2_cosine_core_macros.svh
// Assertion helpers, clocked on clk and held off during reset.
`ifndef VECTOR_DISTANCE_L2_COSINE_CORE_MACROS_SVH
`define VECTOR_DISTANCE_L2_COSINE_CORE_MACROS_SVH

`define VDLC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define VDLC_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: hdl/vdlc_pkg.sv
package vdlc_pkg;
	localparam int ELEM_W      = 16;
	localparam int IN_DATA_W   = 32;
	localparam int DIST_W      = 24;
	localparam int OUT_DATA_W  = 24;
	localparam int MODE_W      = 2;
	localparam int QUOT_W      = 17;
	localparam int MAX_DIM_DEF = 4096;

	localparam logic [MODE_W-1:0] MODE_L2    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COS   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INNER = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RSVD  = 2'd3;

	localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;
	localparam logic [DIST_W-1:0] ONE_Q16  = 24'd65536;
	localparam logic [DIST_W-1:0] TWO_Q16  = 24'd131072;
endpackage

// File: hdl/vector_distance_l2_cosine_core.sv
// Datapath: one shared multiplier, then the add into the accumulator; cosine runs its three
// products (q*n, q*q, n*n) in turn; unsupported modes accumulate nothing and flag the result invalid.
// After the last pair: L2 takes one root of SQ_W/2 steps; cosine takes two roots, one multiply,
// a check and a 17-step divide, skips the divide when the check decides, and skips all on a zero
// norm. Input stalls while a pair is in work; after a last pair, until its result is loaded into the output register.
// Reset (async, active low) clears accumulators, mode (L2) and all handshake state.
`include "vector_distance_l2_cosine_core_macros.svh"

module vector_distance_l2_cosine_core #(
	parameter int MaxDim = vdlc_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [vdlc_pkg::IN_DATA_W-1:0]    s_tdata,  // query_elem, neighbor_elem
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [vdlc_pkg::OUT_DATA_W-1:0]   m_tdata,  // distance
	output logic                              m_tuser,  // invalid
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [vdlc_pkg::MODE_W-1:0]       cfg_data
);
	import vdlc_pkg::*;

	localparam int ACC_W = $clog2(MaxDim) + 34;
	localparam int SQ_W  = 2 * ((ACC_W + 3) / 2);
	localparam int RT_W  = SQ_W / 2;
	localparam int MW    = RT_W + 1;
	localparam int NUM_W = ACC_W + 2;
	localparam longint L2_LIM_L = (longint'(MaxDim) << 32) - 1;
	localparam longint CS_LIM_L = longint'(MaxDim) << 30;
	localparam logic signed [ACC_W-1:0] L2_LIM = ACC_W'(L2_LIM_L);
	localparam logic signed [ACC_W-1:0] CS_LIM = ACC_W'(CS_LIM_L);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_ADD, S_FIN, S_SQA, S_SQB, S_MULD, S_CHK, S_DIV, S_OUT
	} state_t;

	state_t                    state_q;
	logic [MODE_W-1:0]         mode_q;
	logic signed [ELEM_W-1:0]  q_q, n_q;
	logic                      last_q;
	logic [1:0]                sel_q;
	logic signed [ACC_W-1:0]   main_sum_q, qn_sum_q, nn_sum_q;
	logic signed [2*MW-1:0]    prod_q;
	logic [RT_W-1:0]           rq_q;
	logic [DIST_W-1:0]         res_q;
	logic                      inval_q;

	logic signed [MW-1:0]      mul_a, mul_b;
	logic signed [ELEM_W:0]    diff;
	logic signed [ACC_W-1:0]   prod_ext, add_main, add_qn, add_nn;
	logic                      sq_start, sq_done, dv_start, dv_done;
	logic [SQ_W-1:0]           sq_x;
	logic [RT_W-1:0]           sq_root;
	logic [ACC_W-1:0]          dd;
	logic signed [NUM_W-1:0]   num;
	logic                      zero_norm, num_le0, num_ge2d;
	logic [QUOT_W-1:0]         quot;
	logic                      out_free;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid || m_tready;

	assign diff = (ELEM_W+1)'(q_q) - (ELEM_W+1)'(n_q);

	always_comb begin
		if (state_q == S_MULD) begin
			mul_a = $signed({1'b0, rq_q});
			mul_b = $signed({1'b0, sq_root});
		end else if (mode_q == MODE_L2) begin
			mul_a = MW'(diff);
			mul_b = MW'(diff);
		end else begin
			case (sel_q)
				2'd0:    begin mul_a = MW'(q_q); mul_b = MW'(n_q); end
				2'd1:    begin mul_a = MW'(q_q); mul_b = MW'(q_q); end
				default: begin mul_a = MW'(n_q); mul_b = MW'(n_q); end
			endcase
		end
	end

	assign prod_ext = ACC_W'(prod_q);
	assign add_main = main_sum_q + prod_ext;
	assign add_qn   = qn_sum_q + prod_ext;
	assign add_nn   = nn_sum_q + prod_ext;

	assign zero_norm = (qn_sum_q == '0) || (nn_sum_q == '0);

	always_comb begin
		if (state_q == S_FIN) begin
			if (mode_q == MODE_L2) begin
				sq_x = main_sum_q[ACC_W-1] ? '0 : SQ_W'({main_sum_q, 2'b00});
			end else begin
				sq_x = SQ_W'(qn_sum_q);
			end
		end else begin
			sq_x = SQ_W'(nn_sum_q);
		end
	end

	assign sq_start = ((state_q == S_FIN) && (mode_q == MODE_L2 || !zero_norm)) ||
		((state_q == S_SQA) && sq_done && (mode_q == MODE_COS));

	// D = rq * rn, never above the norm limit
	assign dd       = prod_q[ACC_W-1:0];
	assign num      = $signed({2'b00, dd}) - NUM_W'(main_sum_q);
	assign num_le0  = (num <= 0);
	assign num_ge2d = ($unsigned(num) >= {1'b0, dd, 1'b0});
	assign dv_start = (state_q == S_CHK) && !num_le0 && !num_ge2d;

	vdlc_sqrt #(.SqW(SQ_W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .x(sq_x),
		.done(sq_done), .root(sq_root)
	);

	vdlc_div #(.NumW(ACC_W + 1)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.num(num[ACC_W:0]), .den({1'b0, dd}),
		.done(dv_done), .quot(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= MODE_L2;
			main_sum_q <= '0;
			qn_sum_q   <= '0;
			nn_sum_q   <= '0;
			m_tvalid   <= 1'b0;
			sel_q      <= '0;
			last_q     <= 1'b0;
			inval_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			// S_OUT reloads the output register itself
			if (m_tvalid && m_tready && state_q != S_OUT) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						last_q <= s_tlast;
						sel_q  <= '0;
						if (mode_q == MODE_L2 || mode_q == MODE_COS) begin
							inval_q <= 1'b0;
							state_q <= S_MUL;
						end else if (s_tlast) begin
							inval_q <= 1'b1;
							res_q   <= '0;
							state_q <= S_OUT;
						end
					end
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					if (mode_q == MODE_L2) begin
						main_sum_q <= (add_main > L2_LIM) ? L2_LIM : add_main;
					end else begin
						case (sel_q)
							2'd0: begin
								if (add_main > CS_LIM) main_sum_q <= CS_LIM;
								else if (add_main < -CS_LIM) main_sum_q <= -CS_LIM;
								else main_sum_q <= add_main;
							end
							2'd1: qn_sum_q <= (add_qn > CS_LIM) ? CS_LIM : add_qn;
							default: nn_sum_q <= (add_nn > CS_LIM) ? CS_LIM : add_nn;
						endcase
					end
					if (mode_q == MODE_COS && sel_q != 2'd2) begin
						sel_q   <= sel_q + 1'b1;
						state_q <= S_MUL;
					end else begin
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					if (mode_q == MODE_COS && zero_norm) begin
						res_q   <= ONE_Q16;
						state_q <= S_OUT;
					end else begin
						state_q <= S_SQA;
					end
				end
				S_SQA: begin
					if (sq_done) begin
						if (mode_q == MODE_L2) begin
							res_q   <= (sq_root > RT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sq_root);
							state_q <= S_OUT;
						end else begin
							rq_q    <= sq_root;
							state_q <= S_SQB;
						end
					end
				end
				S_SQB: if (sq_done) state_q <= S_MULD;
				S_MULD: state_q <= S_CHK;
				S_CHK: begin
					if (num_le0) begin
						res_q   <= '0;
						state_q <= S_OUT;
					end else if (num_ge2d) begin
						res_q   <= TWO_Q16;
						state_q <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (dv_done) begin
						res_q   <= DIST_W'(quot);
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid   <= 1'b1;
						main_sum_q <= '0;
						qn_sum_q   <= '0;
						nn_sum_q   <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// input capture, shared multiplier (registered before use) and output register
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			q_q <= $signed(s_tdata[15:0]);
			n_q <= $signed(s_tdata[31:16]);
		end
		if (state_q == S_MUL || state_q == S_MULD) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == S_OUT && out_free) begin
			m_tdata <= res_q;
			m_tuser <= inval_q;
		end
	end

	`VDLC_NEVER(a_inval_zero, m_tvalid && m_tuser && (m_tdata != '0), "invalid result with nonzero distance")
	`VDLC_ASSERT(a_clear_on_out, $rose(m_tvalid) |-> (main_sum_q == '0 && qn_sum_q == '0), "sums not cleared after result")
	`VDLC_ASSERT(a_div_cos, (state_q == S_DIV) |-> (mode_q == MODE_COS), "divide outside cosine mode")
endmodule

// File: hdl/vdlc_sqrt.sv
module vdlc_sqrt #(
	parameter int SqW = 36
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SqW-1:0]   x,
	output logic             done,
	output logic [SqW/2-1:0] root
);
	import vdlc_pkg::*;

	logic [SqW-1:0] rem_q, res_q, bit_q, trial;
	logic           busy_q, done_q;

	assign trial = res_q + bit_q;
	assign done  = done_q;
	assign root  = res_q[SqW/2-1:0];

	// restoring form, iterative; a new start while busy restarts the root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && bit_q[0];
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= x;
			res_q <= '0;
			bit_q <= {2'b01, {(SqW-2){1'b0}}};
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

// File: hdl/vdlc_div.sv
module vdlc_div #(
	parameter int NumW = 47
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NumW-1:0]            num,
	input  logic [NumW-1:0]            den,
	output logic                       done,
	output logic [vdlc_pkg::QUOT_W-1:0] quot
);
	import vdlc_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W + 1);

	logic [NumW-1:0]   rem_q, den_q;
	logic [NumW:0]     tmp;
	logic [QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, first_q, done_q;

	// num < 2*den, so the first step needs no shift
	assign tmp  = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(QUOT_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= num;
			den_q   <= den;
			quot_q  <= '0;
			first_q <= 1'b1;
		end else if (busy_q) begin
			first_q <= 1'b0;
			if (tmp >= {1'b0, den_q}) begin
				rem_q  <= NumW'(tmp - {1'b0, den_q});
				quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= tmp[NumW-1:0];
				quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
			end
		end
	end
endmodule

// File: sim/vector_distance_l2_cosine_core_test.sv
`timescale 1ns / 100ps

module vector_distance_l2_cosine_core_test;
	import vdlc_pkg::*;

	typedef struct {
		logic [DIST_W-1:0] distance;
		logic              invalid;
	} dist_result_t;

	class dist_scoreboard;
		localparam longint L2_LIM   = (longint'(MAX_DIM_DEF) << 32) - 1;
		localparam longint COS_LIM  = longint'(MAX_DIM_DEF) << 30;

		logic [MODE_W-1:0] mode;
		longint            main_acc;
		longint            q_norm;
		longint            n_norm;
		dist_result_t      pending_q[$];
		int                fails;

		function new();
			mode = MODE_L2;
			main_acc = 0;
			q_norm = 0;
			n_norm = 0;
			fails = 0;
		endfunction

		function longint int_root(longint x);
			longint r;
			longint b;
			r = 0;
			b = longint'(1) << 62;
			while (b > x)
				b = b >>> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >>> 1) + b;
				end else begin
					r = r >>> 1;
				end
				b = b >>> 2;
			end
			return r;
		endfunction

		// accepted request: accumulate and, on last, queue the expected distance
		function void note_request(logic signed [ELEM_W-1:0] q, logic signed [ELEM_W-1:0] n,
				logic last);
			longint qv;
			longint nv;
			longint s;
			longint d;
			longint num;
			dist_result_t r;
			qv = q;
			nv = n;
			if (mode == MODE_L2) begin
				s = main_acc + (qv - nv) * (qv - nv);
				main_acc = (s > L2_LIM) ? L2_LIM : s;
			end else if (mode == MODE_COS) begin
				s = main_acc + qv * nv;
				if (s > COS_LIM) s = COS_LIM;
				if (s < -COS_LIM) s = -COS_LIM;
				main_acc = s;
				q_norm = (q_norm + qv * qv > COS_LIM) ? COS_LIM : q_norm + qv * qv;
				n_norm = (n_norm + nv * nv > COS_LIM) ? COS_LIM : n_norm + nv * nv;
			end
			if (!last) return;
			r.distance = '0;
			r.invalid = 1'b0;
			if (mode == MODE_L2) begin
				d = int_root(((main_acc < 0) ? 0 : main_acc) << 2);
				r.distance = (d > longint'(DIST_MAX)) ? DIST_MAX : d[DIST_W-1:0];
			end else if (mode == MODE_COS) begin
				if (q_norm == 0 || n_norm == 0) begin
					r.distance = ONE_Q16;
				end else begin
					d = int_root(q_norm) * int_root(n_norm);
					num = d - main_acc;
					if (num <= 0) r.distance = '0;
					else if (num >= 2 * d) r.distance = TWO_Q16;
					else r.distance = DIST_W'((num << 16) / d);
				end
			end else begin
				r.invalid = 1'b1;
			end
			main_acc = 0;
			q_norm = 0;
			n_norm = 0;
			pending_q.push_back(r);
		endfunction

		function void check_result(logic [DIST_W-1:0] distance, logic invalid);
			dist_result_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected result distance=%0d invalid=%0d", distance, invalid);
				fails++;
				return;
			end
			e = pending_q.pop_front();
			if (distance !== e.distance) begin
				$error("distance: expected %0d, actual %0d", e.distance, distance);
				fails++;
			end
			if (invalid !== e.invalid) begin
				$error("invalid: expected %0d, actual %0d", e.invalid, invalid);
				fails++;
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_ITEMS = 1330;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [MODE_W-1:0]     cfg_data;

	dist_scoreboard sb;
	bit             quiet;
	int             cycles;

	vector_distance_l2_cosine_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("vector_distance_l2_cosine_core_test failed");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[DIST_W-1:0], m_tuser);

	task automatic send_pair(logic [ELEM_W-1:0] q, logic [ELEM_W-1:0] n, logic last);
		if (!quiet && $urandom_range(99) < 8) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {n, q};
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
		sb.note_request(q, n, last);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending_q.size() != 0) @(negedge clk);
		// non-last pairs leave no result; let the datapath settle
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(logic [MODE_W-1:0] m);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_data = m;
		do @(posedge clk); while (!cfg_ready);
		sb.mode = m;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [ELEM_W-1:0] pick_elem();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return ELEM_W'($urandom());
		endcase
	endfunction

	initial begin
		int len;
		int items;
		sb = new();
		quiet = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = MODE_L2;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// L2 extremes
		send_pair(16'h7FFF, 16'h8000, 1'b1);
		send_pair(16'h0000, 16'h0000, 1'b1);
		send_pair(16'h8000, 16'h7FFF, 1'b0);
		send_pair(16'h1234, 16'hFEDC, 1'b1);
		// cosine: zero norm, same, opposite, orthogonal
		write_mode(MODE_COS);
		send_pair(16'h0000, 16'h4000, 1'b1);
		send_pair(16'h4000, 16'h0000, 1'b1);
		send_pair(16'h4000, 16'h4000, 1'b1);
		send_pair(16'h7FFF, 16'h8000, 1'b1);
		send_pair(16'h4000, 16'h0000, 1'b0);
		send_pair(16'h0000, 16'h4000, 1'b1);
		// mode switch mid-vector: negative dot read back in L2
		send_pair(16'h7FFF, 16'h8000, 1'b0);
		write_mode(MODE_L2);
		send_pair(16'h0000, 16'h0000, 1'b1);
		// unsupported metrics
		write_mode(MODE_INNER);
		send_pair(16'h7FFF, 16'h7FFF, 1'b0);
		send_pair(16'h8000, 16'h0001, 1'b1);
		write_mode(MODE_RSVD);
		send_pair(16'h5555, 16'hAAAA, 1'b1);
		write_mode(MODE_L2);

		// sender holds off until all results are back
		wait_drained();

		items = 0;
		while (items < RANDOM_ITEMS) begin
			quiet = (items >= 500 && items < 750);
			if ($urandom_range(9) == 0)
				write_mode($urandom_range(9) < 8 ? MODE_W'($urandom_range(1, 0))
					: MODE_W'($urandom_range(3, 2)));
			len = ($urandom_range(19) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			for (int i = 0; i < len; i++) begin
				// occasional stray last mid-vector
				send_pair(pick_elem(), pick_elem(),
					(i == len - 1) || ($urandom_range(49) == 0));
				items++;
			end
		end
		quiet = 1'b0;

		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.fails == 0 && sb.pending_q.size() == 0)
			$display("vector_distance_l2_cosine_core_test passed");
		else
			$display("vector_distance_l2_cosine_core_test failed");
		$finish;
	end
endmodule
